// ===== hdl/sse_pkg.sv =====
// Shared constants and types for the shell sort engine.
package sse_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

// ===== hdl/shell_sort_engine.sv =====
// Shell sort engine: collects a set of words, sorts it in a local memory, streams it back.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata/s_tlast. Each beat carries one signed
// word; the store holds up to MAX_ITEMS words and any further words of the set are
// dropped. A beat with s_tlast high closes the set, and its word is stored when there is
// room. The block then sorts the set in place with halving gaps and emits the words in
// ascending order on m_tvalid/m_tready/m_tdata/m_tlast/m_tuser, with m_tlast on the final
// word and m_tuser high on every word of a set that lost words.
// Loading accepts one beat per cycle. The sort runs on a single memory with one read and
// one write port: each key is fetched (ST_KEY, ST_KEYD), then compared in turn with the
// words a gap apart below it, each larger word being shifted up by the gap, and then placed;
// this repeats for every key over floor(log2(n)) gaps for n words.
// Each sorted beat is read from the memory (ST_OUT, ST_OUTD) into an output register,
// and a new beat is loaded only when that register is empty or being taken; a stalled receiver simply holds the
// output register and the read sequence waits. Input is refused from the closing beat
// until the final sorted word sits in the output register, and the next set may load
// while it waits.
// Reset is synchronous; it empties the set and clears the overflow flag and the output
// valid. Memory contents need no clearing, as only words of the current set are read.
module shell_sort_engine
  import sse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] item_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflowed
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_KEYD = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;
  localparam logic [2:0] ST_NEXT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam logic [2:0] ST_OUTD = 3'd7;

  word_t store [MAX_ITEMS];
  word_t rdata;

  logic [2:0] state, state_next;
  cnt_t       count, count_next;
  logic       drop, drop_next;
  idx_t       gap, gap_next;
  cnt_t       pos, pos_next;
  idx_t       lo, lo_next;
  word_t      key, key_next;

  idx_t  rd_addr;
  logic  wr_en;
  idx_t  wr_addr;
  word_t wr_data;

  logic  in_beat, out_beat, room, greater;
  cnt_t  n_fin, pos_inc;
  idx_t  hi, half_gap;
  logic  load_out;

  assign s_tready = (state == ST_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign room     = (count < cnt_t'(MAX_ITEMS));
  assign n_fin    = room ? count + cnt_t'(1) : count;
  assign greater  = (rdata > key);
  assign hi       = lo + gap;
  assign pos_inc  = pos + cnt_t'(1);
  assign half_gap = gap >> 1;

  always_comb begin
    state_next = state;
    count_next = count;
    drop_next  = drop;
    gap_next   = gap;
    pos_next   = pos;
    lo_next    = lo;
    key_next   = key;
    rd_addr    = pos[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = count[IDX_W-1:0];
    wr_data    = s_tdata;
    load_out   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_beat) begin
          if (room) begin
            wr_en      = 1'b1;
            count_next = count + cnt_t'(1);
          end else begin
            drop_next = 1'b1;
          end
          if (s_tlast) begin
            count_next = n_fin;
            gap_next   = n_fin[CNT_W-1:1];
            pos_next   = cnt_t'(n_fin[CNT_W-1:1]);
            if (n_fin[CNT_W-1:1] == '0) begin
              pos_next   = '0;
              state_next = ST_OUT;
            end else begin
              state_next = ST_KEY;
            end
          end
        end
      end
      ST_KEY: begin
        rd_addr    = pos[IDX_W-1:0];
        state_next = ST_KEYD;
      end
      ST_KEYD: begin
        key_next   = rdata;
        lo_next    = pos[IDX_W-1:0] - gap;
        rd_addr    = pos[IDX_W-1:0] - gap;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        if (greater) begin
          wr_data = rdata;
          if (lo >= gap) begin
            lo_next = lo - gap;
            rd_addr = lo - gap;
          end else begin
            state_next = ST_PUT;
          end
        end else begin
          wr_data    = key;
          state_next = ST_NEXT;
        end
      end
      ST_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = lo;
        wr_data    = key;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (pos_inc < count) begin
          pos_next   = pos_inc;
          state_next = ST_KEY;
        end else if (half_gap == '0) begin
          pos_next   = '0;
          state_next = ST_OUT;
        end else begin
          gap_next   = half_gap;
          pos_next   = cnt_t'(half_gap);
          state_next = ST_KEY;
        end
      end
      ST_OUT: begin
        rd_addr = pos[IDX_W-1:0];
        if (!m_tvalid || m_tready) begin
          state_next = ST_OUTD;
        end
      end
      ST_OUTD: begin
        load_out = 1'b1;
        if (pos_inc == count) begin
          count_next = '0;
          drop_next  = 1'b0;
          state_next = ST_LOAD;
        end else begin
          pos_next   = pos_inc;
          state_next = ST_OUT;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      drop     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      drop  <= drop_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (out_beat) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gap <= gap_next;
    pos <= pos_next;
    lo  <= lo_next;
    key <= key_next;
    if (load_out) begin
      m_tdata    <= rdata;
      m_tlast    <= (pos_inc == count);
      m_tuser[0] <= drop;
    end
  end

endmodule

// ===== tb/sv/shell_sort_engine_tb.sv =====
// Self-checking testbench for the shell sort engine: sets of signed words in, sorted beats out.
module shell_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sse_pkg::*;

  localparam int    CYCLE_LIMIT  = 1000000;
  localparam int    DRAIN_CYCLES = 400;
  localparam int    RANDOM_WORDS = 320;
  localparam word_t WORD_MIN     = 32'sh80000000;
  localparam word_t WORD_MAX     = 32'sh7fffffff;

  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EDGE} fill_t;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_beat_t;

  class sort_scoreboard;
    word_t        held[MAX_ITEMS];
    int           held_count;
    bit           dropped;
    sorted_beat_t pending[$];
    int           errors;
    int           checked;
    int           sets;
    int           overflow_sets;

    function new();
      held_count    = 0;
      dropped       = 0;
      errors        = 0;
      checked       = 0;
      sets          = 0;
      overflow_sets = 0;
    endfunction

    function void note_word(word_t value, logic last);
      int           gap;
      int           pos;
      int           lo;
      word_t        t;
      sorted_beat_t beat;
      if (held_count < MAX_ITEMS) begin
        held[held_count] = value;
        held_count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      for (gap = held_count / 2; gap > 0; gap = gap / 2) begin
        for (pos = gap; pos < held_count; pos++) begin
          lo = pos - gap;
          while (lo >= 0 && held[lo] > held[lo + gap]) begin
            t              = held[lo];
            held[lo]       = held[lo + gap];
            held[lo + gap] = t;
            lo             = lo - gap;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        beat.value = held[k];
        beat.last  = (k == held_count - 1);
        beat.ovf   = dropped;
        pending.push_back(beat);
      end
      sets++;
      if (dropped) overflow_sets++;
      held_count = 0;
      dropped    = 0;
    endfunction

    function void check_result(word_t value, logic last, logic ovf);
      sorted_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, value %0d last %0b overflow %0b",
                 $time, value, last, ovf);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (value !== want.value) begin
        $display("%0t: sorted value mismatch, expected %0d, actual %0d",
                 $time, $signed(want.value), value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: tlast mismatch, expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow flag mismatch, expected %0b, actual %0b",
                 $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] item_value
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] sorted_value
  logic        m_tlast;
  logic [0:0]  m_tuser;         // [0] overflowed

  sort_scoreboard sb = new();
  int             cycle_count = 0;
  int             words_sent  = 0;
  int             send_run    = 0;
  int             recv_run    = 0;

  shell_sort_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_cycles(ref int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_word(word_t value, logic last);
    int idle;
    idle = idle_cycles(send_run);
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(value, last);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    int    n;
    fill_t fill;
    word_t v;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
      end
      1: begin
        n = MAX_ITEMS;
      end
      default: begin
        n = $urandom_range(1, MAX_ITEMS - 1);
      end
    endcase
    fill = fill_t'($urandom_range(0, 2));
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_WIDE: begin
          v = $urandom;
        end
        FILL_NARROW: begin
          v = word_t'($urandom_range(0, 8)) - 4;
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       v = WORD_MIN;
            1:       v = WORD_MAX;
            2:       v = '0;
            3:       v = -1;
            default: v = $urandom;
          endcase
        end
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  initial begin : drain_results
    int idle;
    while (rst) @(posedge clk);
    forever begin
      idle = idle_cycles(recv_run);
      if (idle > 0) begin
        m_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tlast, m_tuser[0]);
    end
  end

  initial begin : stimulus
    int random_start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(WORD_MIN, 1'b1);
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b1);
    send_word(32'sd5, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(WORD_MIN, 1'b1);
    for (int i = 0; i <= MAX_ITEMS; i++) begin
      send_word(word_t'(100 - 13 * i), i == MAX_ITEMS);
    end
    wait_drained();

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      send_random_set();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d sets (%0d of them over capacity) from %0d input beats.",
             sb.sets, sb.overflow_sets, words_sent);
    $display("Checked %0d sorted beats against the predicted order and flags.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sse_pkg.sv
hdl/shell_sort_engine.sv
tb/sv/shell_sort_engine_tb.sv
